@@ src/mmul_pkg.sv @@
// types and constants shared by the integer matrix multiply block
package mmul_pkg;

  localparam int IDX_W   = 3;
  localparam int DIM_W   = 4;
  localparam int VALUE_W = 35;
  localparam int IN_W    = 16;
  localparam int CFG_W   = 2;

  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 2;

  localparam logic [1:0] OP_LOAD_A  = 2'd0;
  localparam logic [1:0] OP_LOAD_B  = 2'd1;
  localparam logic [1:0] OP_COMPUTE = 2'd2;

  localparam logic [CFG_W-1:0] CFG_A_ROWS = 2'd0;
  localparam logic [CFG_W-1:0] CFG_A_COLS = 2'd1;
  localparam logic [CFG_W-1:0] CFG_B_ROWS = 2'd2;
  localparam logic [CFG_W-1:0] CFG_B_COLS = 2'd3;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  typedef enum logic [1:0] {
    CMD_LOAD_A,
    CMD_LOAD_B,
    CMD_COMPUTE
  } cmd_kind_t;

  typedef enum logic {
    ENG_IDLE,
    ENG_RUN
  } eng_state_t;

  typedef struct packed {
    logic [1:0]            operation;
    logic [IDX_W-1:0]      elem_row;
    logic [IDX_W-1:0]      elem_col;
    logic signed [IN_W-1:0] elem_value;
  } request_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] product_value;
    logic [IDX_W-1:0]          out_row;
    logic [IDX_W-1:0]          out_col;
    logic                      dim_error;
    logic                      last;
  } result_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic [IDX_W-1:0]       row;
    logic [IDX_W-1:0]       col;
    logic signed [IN_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [DIM_W-1:0] a_rows;
    logic [DIM_W-1:0] a_cols;
    logic [DIM_W-1:0] b_rows;
    logic [DIM_W-1:0] b_cols;
  } cfg_t;

endpackage

@@ src/integer_matrix_multiply_top.sv @@
// top level of the signed integer matrix multiplier
// request channel: push/full; an item is taken when push is high and full is low.
//   load A / load B items write one element; compute items produce results.
//   loads outside the matrix range and the unused operation code are dropped.
// result channel: empty/pop; the oldest result waits on result while empty is low.
// config port cfg_write/cfg_index/cfg_data: write only while idle; unchecked.
// dimensions of 0 count as 1 and those above MAX_DIM as MAX_DIM; a compute item
//   yields a_rows * b_cols results in row-major order, last on the final one,
//   or a single dim_error result when a_cols differs from b_rows.
// loads are taken back to back; each result element sums a_cols products, one per
//   cycle through the shared multiply-accumulate while the result queue accepts.
// the command queue and result queue hold two items each.
// when the receiver stalls, the multiply pipeline holds, the command queue fills
//   and full rises.
// reset clears the queues and sets all four dimension registers to 8; the element
//   stores are not cleared and must be written before use.
module integer_matrix_multiply_top #(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  input  mmul_pkg::request_t                 request,
  output logic                               full,
  output logic                               empty,
  input  logic                               pop,
  output mmul_pkg::result_t                  result,
  input  logic                               cfg_write,
  input  logic [mmul_pkg::CFG_W-1:0]         cfg_index,
  input  logic [mmul_pkg::DIM_W-1:0]         cfg_data
);

  mmul_pkg::cfg_t    cfg;
  mmul_pkg::cmd_t    front_cmd;
  mmul_pkg::cmd_t    cmd;
  mmul_pkg::result_t res;
  logic              cmd_full;
  logic              cmd_push;
  logic              cmd_empty;
  logic              cmd_pop;
  logic              res_full;
  logic              res_push;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.a_rows <= mmul_pkg::DIM_RESET;
      cfg.a_cols <= mmul_pkg::DIM_RESET;
      cfg.b_rows <= mmul_pkg::DIM_RESET;
      cfg.b_cols <= mmul_pkg::DIM_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        mmul_pkg::CFG_A_ROWS: cfg.a_rows <= cfg_data;
        mmul_pkg::CFG_A_COLS: cfg.a_cols <= cfg_data;
        mmul_pkg::CFG_B_ROWS: cfg.b_rows <= cfg_data;
        mmul_pkg::CFG_B_COLS: cfg.b_cols <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  mmul_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .push     (push),
    .request  (request),
    .full     (full),
    .cmd_full (cmd_full),
    .cmd_push (cmd_push),
    .cmd      (front_cmd)
  );

  mmul_fifo #(
    .item_t (mmul_pkg::cmd_t),
    .DEPTH  (mmul_pkg::CMD_DEPTH)
  ) u_cmd_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (cmd_push),
    .wr_item (front_cmd),
    .full    (cmd_full),
    .pop     (cmd_pop),
    .rd_item (cmd),
    .empty   (cmd_empty)
  );

  mmul_engine #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_empty (cmd_empty),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  mmul_fifo #(
    .item_t (mmul_pkg::result_t),
    .DEPTH  (mmul_pkg::RES_DEPTH)
  ) u_res_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .wr_item (res),
    .full    (res_full),
    .pop     (pop),
    .rd_item (result),
    .empty   (empty)
  );

  // an error result is a lone, zeroed item
  a_error_result: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.dim_error) |->
      (result.last && result.product_value == '0 && result.out_row == '0 &&
       result.out_col == '0))
    else $error("dimension error result not zeroed");

  // result positions stay inside the matrix
  a_result_range: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.dim_error) |->
      (int'(result.out_row) < MAX_DIM && int'(result.out_col) < MAX_DIM))
    else $error("result position out of range");

  // nothing is waiting right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (empty && !full))
    else $error("queues not empty after reset");

endmodule

@@ src/mmul_fifo.sv @@
// small first-in first-out queue of packed items
module mmul_fifo #(
  parameter type item_t = logic,
  parameter int  DEPTH  = 2
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t wr_item,
  output logic  full,
  input  logic  pop,
  output item_t rd_item,
  output logic  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t         slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

endmodule

@@ src/mmul_front.sv @@
// front end: accepts request items and classifies them into commands
module mmul_front #(
  parameter int MAX_DIM = 8
) (
  input  logic               push,
  input  mmul_pkg::request_t request,
  output logic               full,
  input  logic               cmd_full,
  output logic               cmd_push,
  output mmul_pkg::cmd_t     cmd
);

  logic in_range;
  logic keep;

  assign in_range = (int'(request.elem_row) < MAX_DIM) && (int'(request.elem_col) < MAX_DIM);
  assign full     = cmd_full;
  assign cmd_push = push && !cmd_full && keep;

  always_comb begin
    keep      = 1'b0;
    cmd.kind  = mmul_pkg::CMD_COMPUTE;
    cmd.row   = request.elem_row;
    cmd.col   = request.elem_col;
    cmd.value = request.elem_value;
    case (request.operation)
      mmul_pkg::OP_LOAD_A: begin
        cmd.kind = mmul_pkg::CMD_LOAD_A;
        keep     = in_range;
      end
      mmul_pkg::OP_LOAD_B: begin
        cmd.kind = mmul_pkg::CMD_LOAD_B;
        keep     = in_range;
      end
      mmul_pkg::OP_COMPUTE: begin
        cmd.kind = mmul_pkg::CMD_COMPUTE;
        keep     = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

endmodule

@@ src/mmul_engine.sv @@
// back end: element stores, sequencer and pipelined multiply-accumulate
module mmul_engine #(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  mmul_pkg::cfg_t    cfg,
  input  logic              cmd_empty,
  input  mmul_pkg::cmd_t    cmd,
  output logic              cmd_pop,
  input  logic              res_full,
  output logic              res_push,
  output mmul_pkg::result_t res
);

  localparam int CELLS = MAX_DIM * MAX_DIM;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int IW    = mmul_pkg::IDX_W;
  localparam int VW    = mmul_pkg::VALUE_W;
  localparam int PW    = 2 * ELEM_WIDTH;

  typedef struct packed {
    logic          valid;
    logic          err;
    logic          first_k;
    logic          last_k;
    logic          last;
    logic [IW-1:0] row;
    logic [IW-1:0] col;
  } tok_t;

  function automatic logic [IW-1:0] dim_m1(input logic [mmul_pkg::DIM_W-1:0] v);
    logic [mmul_pkg::DIM_W-1:0] t;
    t = v - 4'd1;
    if (v == '0) begin
      return '0;
    end else if (int'(v) > MAX_DIM) begin
      return IW'(MAX_DIM - 1);
    end
    return t[IW-1:0];
  endfunction

  logic [ELEM_WIDTH-1:0] mem_a [CELLS];
  logic [ELEM_WIDTH-1:0] mem_b [CELLS];

  mmul_pkg::eng_state_t state;
  mmul_pkg::eng_state_t state_next;

  logic [IW-1:0] r;
  logic [IW-1:0] c;
  logic [IW-1:0] k;
  logic [IW-1:0] ar_m1;
  logic [IW-1:0] ac_m1;
  logic [IW-1:0] bc_m1;
  tok_t          s1;
  tok_t          s2;
  tok_t          tok_new;

  logic signed [ELEM_WIDTH-1:0] a_q;
  logic signed [ELEM_WIDTH-1:0] b_q;
  logic signed [PW-1:0]         mult;
  logic signed [63:0]           mult_wide;
  logic [VW-1:0]                prod;
  logic [VW-1:0]                acc;
  logic [VW-1:0]                sum;

  logic                  emit;
  logic                  adv;
  logic                  wr_a;
  logic                  wr_b;
  logic                  load_dims;
  logic                  mismatch;
  logic [AW-1:0]         wa;
  logic [AW-1:0]         ra;
  logic [AW-1:0]         rb;
  logic signed [31:0]    v32;
  logic [ELEM_WIDTH-1:0] wv;

  assign emit     = s2.valid && (s2.err || s2.last_k);
  assign adv      = !(emit && res_full);
  assign res_push = emit && !res_full;
  assign sum      = (s2.first_k ? '0 : acc) + prod;

  assign res.product_value = s2.err ? '0 : signed'(sum);
  assign res.out_row       = s2.row;
  assign res.out_col       = s2.col;
  assign res.dim_error     = s2.err;
  assign res.last          = s2.last;

  assign mismatch = (dim_m1(cfg.a_cols) != dim_m1(cfg.b_rows));

  assign v32 = 32'(cmd.value);
  assign wv  = v32[ELEM_WIDTH-1:0];
  assign wa  = AW'(int'(cmd.row) * MAX_DIM + int'(cmd.col));
  assign ra  = AW'(int'(r) * MAX_DIM + int'(k));
  assign rb  = AW'(int'(k) * MAX_DIM + int'(c));

  assign mult      = a_q * b_q;
  assign mult_wide = 64'(mult);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mmul_pkg::ENG_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    wr_a       = 1'b0;
    wr_b       = 1'b0;
    load_dims  = 1'b0;
    tok_new    = '0;
    case (state)
      mmul_pkg::ENG_IDLE: begin
        if (adv && !cmd_empty) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            mmul_pkg::CMD_LOAD_A: begin
              wr_a = 1'b1;
            end
            mmul_pkg::CMD_LOAD_B: begin
              wr_b = 1'b1;
            end
            mmul_pkg::CMD_COMPUTE: begin
              if (mismatch) begin
                tok_new.valid = 1'b1;
                tok_new.err   = 1'b1;
                tok_new.last  = 1'b1;
              end else begin
                load_dims  = 1'b1;
                state_next = mmul_pkg::ENG_RUN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      mmul_pkg::ENG_RUN: begin
        if (adv) begin
          tok_new.valid   = 1'b1;
          tok_new.first_k = (k == '0);
          tok_new.last_k  = (k == ac_m1);
          tok_new.last    = (k == ac_m1) && (c == bc_m1) && (r == ar_m1);
          tok_new.row     = r;
          tok_new.col     = c;
          if (tok_new.last) begin
            state_next = mmul_pkg::ENG_IDLE;
          end
        end
      end
      default: begin
        state_next = mmul_pkg::ENG_IDLE;
      end
    endcase
  end

  // row, column and inner-product counters
  always_ff @(posedge clk) begin
    if (load_dims) begin
      r     <= '0;
      c     <= '0;
      k     <= '0;
      ar_m1 <= dim_m1(cfg.a_rows);
      ac_m1 <= dim_m1(cfg.a_cols);
      bc_m1 <= dim_m1(cfg.b_cols);
    end else if (state == mmul_pkg::ENG_RUN && adv) begin
      if (k == ac_m1) begin
        k <= '0;
        if (c == bc_m1) begin
          c <= '0;
          r <= r + IW'(1);
        end else begin
          c <= c + IW'(1);
        end
      end else begin
        k <= k + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[wa] <= wv;
    end
    if (wr_b) begin
      mem_b[wa] <= wv;
    end
    if (adv) begin
      a_q <= mem_a[ra];
      b_q <= mem_b[rb];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
      s2 <= '0;
    end else if (adv) begin
      s1 <= tok_new;
      s2 <= s1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod <= mult_wide[VW-1:0];
      if (s2.valid && !s2.err) begin
        acc <= sum;
      end
    end
  end

endmodule
